[rtl/hrts_pkg.sv]
`timescale 1ns / 1ps
package hrts_pkg;

	localparam int RINGS     = 15;
	localparam int RING_W    = (RINGS > 1) ? $clog2(RINGS) : 1;

	localparam int SQ_STEPS  = 16;
	localparam int LOG_LAT   = 1 + SQ_STEPS;
	localparam int PROBES    = 16;
	localparam int DIV_STEPS = 16;
	localparam int RING_LAT  = 3 + LOG_LAT + 1 + PROBES * (LOG_LAT + 1) + 4 + DIV_STEPS + 2;
	localparam int TOTAL_LAT = RING_LAT + 2;

	localparam logic [31:0] HASH_A    = 32'd747796405;
	localparam logic [31:0] HASH_B    = 32'd2654435761;
	localparam logic [20:0] NL_FULL   = 21'd1507328;
	localparam logic [16:0] POW_BASE  = 17'd19661;
	localparam logic [31:0] POW_SPAN  = 32'd45875;
	localparam logic [17:0] MIN_W     = 18'd83886;
	localparam logic [17:0] SPAN_W    = 18'd167772;
	localparam logic [19:0] RECIP5    = 20'd838861;
	localparam logic [17:0] SMOOTH_K  = 18'd196608;
	localparam logic [16:0] S_ONE     = 17'd65536;
	localparam logic [33:0] BLEND_RND = 34'd32768;
	localparam logic [15:0] RING_RST  = 16'd4096;

	localparam logic [1:0] HIT_NONE = 2'd0;
	localparam logic [1:0] HIT_CORE = 2'd1;
	localparam logic [1:0] HIT_EDGE = 2'd2;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RING_RED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RING_GREEN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RING_BLUE  = 3'd5;

	typedef struct packed {
		logic [15:0] curve_position;
		logic [31:0] hair_index;
	} sample_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
		logic [1:0]  hit_kind;
	} shade_t;

	typedef struct packed {
		logic [4:0]  e;
		logic [23:0] m;
		logic [15:0] frac;
	} lg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [16:0] edge_w;
		logic [16:0] rem;
		logic [15:0] quo;
	} div_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [16:0] s;
	} ring_res_t;

	function automatic logic [31:0] seed_term(input logic [RING_W-1:0] k, input logic [1:0] off);
		logic [31:0] sd;
		sd = 32'(k) * 32'd3 + 32'(off);
		return sd * HASH_B;
	endfunction

	function automatic logic [16:0] ring_power(input logic [RING_W-1:0] k);
		return 17'(32'(POW_BASE) + (POW_SPAN * 32'(k)) / RINGS);
	endfunction

endpackage

[rtl/hrts_if.sv]
`timescale 1ns / 1ps
interface hrts_sample_if;
	import hrts_pkg::*;
	logic    valid;
	logic    ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hrts_shade_if;
	import hrts_pkg::*;
	logic   valid;
	logic   ready;
	shade_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/hair_ring_texture_shader_core.sv]
`timescale 1ns / 1ps
// channel  dir  word
// sample   in   curve_position Q0.16, hair_index
// shade    out  out_red/green/blue Q4.12, hit_kind
// cfg      in   cfg_we, cfg_index, cfg_data (16 bit)
//
// One word per cycle while the output buffer has room; the depth comes
// mostly from the per-ring log2 squaring cells of the 16 search probes.
// All ring pipelines and the blend stages advance together; a two-word
// output buffer stalls the whole pipe when full, ready is registered.
// Reset clears valids and the buffer, presets colours; no clearing pass.
module hair_ring_texture_shader_core (
	input  logic                             clk,
	input  logic                             arst_n,
	hrts_sample_if.sink                      sample,
	hrts_shade_if.source                     shade,
	input  logic                             cfg_we,
	input  logic [hrts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                      cfg_data
);
	import hrts_pkg::*;

	logic [15:0] base_q [3];
	logic [15:0] ring_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				base_q[c] <= '0;
				ring_q[c] <= RING_RST;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_RED:   base_q[0] <= cfg_data;
				REG_BASE_GREEN: base_q[1] <= cfg_data;
				REG_BASE_BLUE:  base_q[2] <= cfg_data;
				REG_RING_RED:   ring_q[0] <= cfg_data;
				REG_RING_GREEN: ring_q[1] <= cfg_data;
				REG_RING_BLUE:  ring_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [1:0]           cnt_q;
	logic                 adv;
	logic [TOTAL_LAT-1:0] vld_q;

	assign adv          = (cnt_q != 2'd2);
	assign sample.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], sample.valid};
		end
	end

	ring_res_t rr [RINGS];

	for (genvar g = 0; g < RINGS; g++) begin : g_ring
		hrts_ring u_ring (
			.clk            (clk),
			.en             (adv),
			.ring           (RING_W'(g)),
			.curve_position (sample.data.curve_position),
			.hair_index     (sample.data.hair_index),
			.res            (rr[g])
		);
	end

	// first ring hit wins
	logic [1:0]  kind_sel;
	logic [16:0] s_sel;

	always_comb begin
		kind_sel = HIT_NONE;
		s_sel    = S_ONE;
		for (int i = RINGS - 1; i >= 0; i--) begin
			if (rr[i].kind != HIT_NONE) begin
				kind_sel = rr[i].kind;
				s_sel    = rr[i].s;
			end
		end
	end

	logic [1:0]  kind_s1, kind_s2;
	logic [16:0] s_s1;
	logic [32:0] pr_s2 [3];
	logic [32:0] pb_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind_sel;
			s_s1    <= s_sel;
			kind_s2 <= kind_s1;
			for (int c = 0; c < 3; c++) begin
				pr_s2[c] <= 33'(ring_q[c]) * 33'(S_ONE - s_s1);
				pb_s2[c] <= 33'(base_q[c]) * 33'(s_s1);
			end
		end
	end

	logic [33:0] sum [3];
	logic [15:0] chan [3];
	shade_t      word;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c]  = 34'(pr_s2[c]) + 34'(pb_s2[c]) + BLEND_RND;
			chan[c] = (sum[c][33:32] != 2'b00) ? 16'hFFFF : sum[c][31:16];
		end
		word.out_red   = chan[0];
		word.out_green = chan[1];
		word.out_blue  = chan[2];
		word.hit_kind  = kind_s2;
	end

	// two-word output buffer
	shade_t buf_q [2];
	logic   wp_q, rp_q;
	logic   push, pop;

	assign push        = adv && vld_q[TOTAL_LAT-1];
	assign pop         = shade.valid && shade.ready;
	assign shade.valid = (cnt_q != 2'd0);
	assign shade.data  = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

[rtl/hrts_sq_cell.sv]
`timescale 1ns / 1ps
module hrts_sq_cell (
	input  logic           clk,
	input  logic           en,
	input  hrts_pkg::lg_t  d,
	output hrts_pkg::lg_t  o
);
	import hrts_pkg::*;

	logic [47:0] sq;
	logic [24:0] hi;

	assign sq = 48'(d.m) * 48'(d.m);
	assign hi = sq[47:23];

	always_ff @(posedge clk) begin
		if (en) begin
			o.e <= d.e;
			if (hi[24]) begin
				o.m    <= hi[24:1];
				o.frac <= {d.frac[14:0], 1'b1};
			end else begin
				o.m    <= hi[23:0];
				o.frac <= {d.frac[14:0], 1'b0};
			end
		end
	end
endmodule

[rtl/hrts_log2.sv]
`timescale 1ns / 1ps
module hrts_log2 (
	input  logic        clk,
	input  logic        en,
	input  logic [23:0] v,
	output logic [20:0] lg
);
	import hrts_pkg::*;

	logic [4:0] msb;
	lg_t        norm_s1;
	lg_t        chain [SQ_STEPS+1];

	always_comb begin
		msb = '0;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) msb = 5'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s1.e    <= msb;
			norm_s1.m    <= v << (5'd23 - msb);
			norm_s1.frac <= '0;
		end
	end

	assign chain[0] = norm_s1;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		hrts_sq_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (chain[i]),
			.o   (chain[i+1])
		);
	end

	assign lg = {chain[SQ_STEPS].e, chain[SQ_STEPS].frac};
endmodule

[rtl/hrts_div_cell.sv]
`timescale 1ns / 1ps
module hrts_div_cell (
	input  logic           clk,
	input  logic           en,
	input  hrts_pkg::div_t d,
	output hrts_pkg::div_t o
);
	import hrts_pkg::*;

	logic [17:0] dbl;

	assign dbl = {d.rem, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			o.kind   <= d.kind;
			o.edge_w <= d.edge_w;
			if (dbl >= {1'b0, d.edge_w}) begin
				o.rem <= 17'(dbl - {1'b0, d.edge_w});
				o.quo <= {d.quo[14:0], 1'b1};
			end else begin
				o.rem <= dbl[16:0];
				o.quo <= {d.quo[14:0], 1'b0};
			end
		end
	end
endmodule

[rtl/hrts_ring.sv]
`timescale 1ns / 1ps
module hrts_ring (
	input  logic                        clk,
	input  logic                        en,
	input  logic [hrts_pkg::RING_W-1:0] ring,
	input  logic [15:0]                 curve_position,
	input  logic [31:0]                 hair_index,
	output hrts_pkg::ring_res_t         res
);
	import hrts_pkg::*;

	typedef struct packed {
		logic [15:0] t;
		logic [22:0] r2;
		logic        zero;
		logic        tz;
		logic [20:0] u;
		logic [15:0] p;
	} ctx_t;

	// hash
	logic [31:0] idx_mul;
	logic [31:0] a1_s1, a2_s1, b1_s2, b2_s2;
	logic [22:0] r1_s3, r2_s3;
	logic [15:0] t_s1, t_s2, t_s3;

	assign idx_mul = hair_index * HASH_A;

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1 <= idx_mul + seed_term(ring, 2'd0);
			a2_s1 <= idx_mul + seed_term(ring, 2'd1);
			t_s1  <= curve_position;
			b1_s2 <= (a1_s1 ^ (a1_s1 >> 13)) * HASH_B;
			b2_s2 <= (a2_s1 ^ (a2_s1 >> 13)) * HASH_B;
			t_s2  <= t_s1;
			r1_s3 <= 23'(b1_s2 ^ (b1_s2 >> 16));
			r2_s3 <= 23'(b2_s2 ^ (b2_s2 >> 16));
			t_s3  <= t_s2;
		end
	end

	// log2 of the position random value
	ctx_t        ctx3;
	ctx_t        lg0_d [LOG_LAT];
	logic [20:0] lg0;

	always_comb begin
		ctx3      = '0;
		ctx3.t    = t_s3;
		ctx3.r2   = r2_s3;
		ctx3.zero = (r1_s3 == '0);
	end

	hrts_log2 u_lg0 (
		.clk (clk),
		.en  (en),
		.v   ({1'b0, r1_s3}),
		.lg  (lg0)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			lg0_d[0] <= ctx3;
			for (int i = 1; i < LOG_LAT; i++) lg0_d[i] <= lg0_d[i-1];
		end
	end

	// power target
	logic [20:0] nl;
	logic [37:0] tprod;
	logic [20:0] tgt;
	ctx_t        ctx4_nx;
	ctx_t        ctx_s4;

	assign nl    = NL_FULL - lg0;
	assign tprod = 38'(ring_power(ring)) * 38'(nl);
	assign tgt   = 21'(tprod >> 16);

	always_comb begin
		ctx4_nx    = lg0_d[LOG_LAT-1];
		ctx4_nx.u  = NL_FULL - tgt;
		ctx4_nx.tz = (tgt == '0);
		ctx4_nx.p  = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx4_nx;
		end
	end

	// bitwise search of the position, one log2 per bit
	ctx_t pin [PROBES+1];
	assign pin[0] = ctx_s4;

	for (genvar j = 0; j < PROBES; j++) begin : g_probe
		localparam logic [15:0] BIT = 16'(1) << (PROBES - 1 - j);
		logic [15:0] cand;
		logic [20:0] lg;
		ctx_t        dl_s [LOG_LAT];
		ctx_t        res_nx;
		ctx_t        res_s;

		assign cand = pin[j].p | BIT;

		hrts_log2 u_lg (
			.clk (clk),
			.en  (en),
			.v   ({1'b0, cand, 7'b0}),
			.lg  (lg)
		);

		always_comb begin
			res_nx = dl_s[LOG_LAT-1];
			if (lg <= dl_s[LOG_LAT-1].u) res_nx.p = dl_s[LOG_LAT-1].p | BIT;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dl_s[0] <= pin[j];
				for (int i = 1; i < LOG_LAT; i++) dl_s[i] <= dl_s[i-1];
				res_s <= res_nx;
			end
		end

		assign pin[j+1] = res_s;
	end

	// ring width and distance
	ctx_t        pout;
	logic [16:0] pos;
	logic [40:0] wx;
	logic [40:0] wx_s5;
	logic [16:0] pos_s5;
	logic [15:0] t_s5;
	logic [57:0] wp;
	logic [17:0] w;
	logic [16:0] tt, dif;
	logic [16:0] half_s6, half_s7;
	logic [24:0] d_s6, d_s7;
	logic [38:0] e5;
	logic [16:0] edge_s7;

	assign pout = pin[PROBES];
	assign pos  = pout.zero ? 17'd0 : (pout.tz ? S_ONE : {1'b0, pout.p});
	assign wx   = 41'(SPAN_W) * 41'(pout.r2);

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s5  <= wx;
			pos_s5 <= pos;
			t_s5   <= pout.t;
		end
	end

	assign wp  = 58'(wx_s5) * 58'({1'b0, t_s5} + S_ONE);
	assign w   = MIN_W + wp[57:40];
	assign tt  = {1'b0, t_s5};
	assign dif = (tt > pos_s5) ? (tt - pos_s5) : (pos_s5 - tt);

	always_ff @(posedge clk) begin
		if (en) begin
			half_s6 <= w[17:1];
			d_s6    <= {dif, 8'b0};
		end
	end

	assign e5 = 39'({half_s6, 2'b0}) * 39'(RECIP5);

	always_ff @(posedge clk) begin
		if (en) begin
			edge_s7 <= 17'(e5 >> 22);
			half_s7 <= half_s6;
			d_s7    <= d_s6;
		end
	end

	// classify
	logic [16:0] inner;
	logic        hit, core;
	div_t        dv [DIV_STEPS+1];
	div_t        dv_s8;

	assign inner = half_s7 - edge_s7;
	assign hit   = d_s7 < {8'b0, half_s7};
	assign core  = (d_s7 <= {8'b0, inner}) || (edge_s7 == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s8.kind   <= hit ? (core ? HIT_CORE : HIT_EDGE) : HIT_NONE;
			dv_s8.edge_w <= edge_s7;
			dv_s8.rem    <= 17'(d_s7 - {8'b0, inner});
			dv_s8.quo    <= '0;
		end
	end

	assign dv[0] = dv_s8;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		hrts_div_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (dv[i]),
			.o   (dv[i+1])
		);
	end

	// smoothstep
	logic [15:0] q_s9, b2_s9;
	logic [1:0]  kind_s9;
	logic [31:0] bsq;
	logic [33:0] sm;
	logic [17:0] sv;

	assign bsq = 32'(dv[DIV_STEPS].quo) * 32'(dv[DIV_STEPS].quo);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s9    <= dv[DIV_STEPS].quo;
			b2_s9   <= bsq[31:16];
			kind_s9 <= dv[DIV_STEPS].kind;
		end
	end

	assign sm = 34'(b2_s9) * 34'(SMOOTH_K - {1'b0, q_s9, 1'b0});
	assign sv = sm[33:16];

	// core takes the ring colour as it is
	always_ff @(posedge clk) begin
		if (en) begin
			res.kind <= kind_s9;
			res.s    <= (kind_s9 != HIT_EDGE) ? 17'd0 :
				((sv > {1'b0, S_ONE}) ? S_ONE : sv[16:0]);
		end
	end
endmodule
